### hw/rtl/sha256_pkg.sv
// SHA-256 engine shared package: round and initial constants, the
// command and status bundles between controller and datapath.
// No dependencies.
package sha256_pkg;

   localparam int WordWidth = 32;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] PAD_WORD = 32'h80000000;

   // Source of the next word pushed into the block buffer.
   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_INPUT,
      SRC_LEN_HI,
      SRC_LEN_LO
   } word_src_type;

   typedef struct packed {
      logic         take_input;   // latch the accepted transaction
      logic         push;         // write one word into the buffer
      word_src_type src;
      logic         force_pad;    // push the bare 0x80000000 pad word
      logic         round_start;  // load a..h from the hash
      logic         round_step;   // one compression round
      logic         fold;         // add a..h into the hash
      logic         emit_shift;   // rotate hash toward the digest port
      logic         hash_init;    // return to the initial hash
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] word_index;
      logic [2:0] nbytes;         // clamped byte count of latched word
      logic       last;
   } dp_status_type;

endpackage

### hw/rtl/sha256_datapath.sv
// SHA-256 datapath: block buffer, schedule, one round per cycle, hash
// accumulate and digest rotation. Depends on sha256_pkg.
module sha256_datapath
   import sha256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  logic [31:0]   in_word,
   input  logic [2:0]    in_bytes,
   input  logic          in_last,
   output dp_status_type status,
   output logic [31:0]   digest_word
);

   logic [31:0] w_ff [16];
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [3:0]  idx_ff;
   logic [5:0]  rnd_ff;
   logic [63:0] len_ff;
   logic [31:0] word_ff;
   logic [2:0]  nb_ff;
   logic        last_ff;

   logic [31:0] push_word, keep, pad, s0, s1, wexp, wcur, t1, t2, e, a;
   logic [2:0]  nb_in;
   logic [3:0]  slot;

   always_comb begin
      nb_in = (!in_last || in_bytes > 3'd4) ? 3'd4 : in_bytes;
      keep  = (nb_ff == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {nb_ff, 3'b000}));
      pad   = 32'h80 << (5'd24 - {nb_ff[1:0], 3'b000});
      unique case (cmd.src)
         SRC_ZERO:   push_word = 32'h0;
         SRC_INPUT:  push_word = (nb_ff == 3'd4) ? word_ff : ((word_ff & keep) | pad);
         SRC_LEN_HI: push_word = len_ff[63:32];
         SRC_LEN_LO: push_word = len_ff[31:0];
         default:    push_word = 32'h0;
      endcase
      if (cmd.force_pad) push_word = PAD_WORD;

      slot = rnd_ff[3:0];
      s0 = {w_ff[slot + 4'd1][6:0], w_ff[slot + 4'd1][31:7]}
         ^ {w_ff[slot + 4'd1][17:0], w_ff[slot + 4'd1][31:18]}
         ^ (w_ff[slot + 4'd1] >> 3);
      s1 = {w_ff[slot + 4'd14][16:0], w_ff[slot + 4'd14][31:17]}
         ^ {w_ff[slot + 4'd14][18:0], w_ff[slot + 4'd14][31:19]}
         ^ (w_ff[slot + 4'd14] >> 10);
      wexp = w_ff[slot] + s0 + w_ff[slot + 4'd9] + s1;
      wcur = (rnd_ff >= 6'd16) ? wexp : w_ff[slot];
      e  = v_ff[4];
      a  = v_ff[0];
      t1 = v_ff[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + ROUND_K[rnd_ff] + wcur;
      t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (cmd.take_input) begin
         word_ff <= in_word;
         nb_ff   <= nb_in;
         last_ff <= in_last;
      end
      if (cmd.push) w_ff[idx_ff] <= push_word;
      if (cmd.round_start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (cmd.round_step) begin
         w_ff[slot] <= wcur;
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.hash_init) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
         idx_ff <= '0;
         len_ff <= '0;
         rnd_ff <= '0;
      end else begin
         if (cmd.take_input) len_ff <= len_ff + {58'd0, nb_in, 3'b000};
         if (cmd.push) idx_ff <= idx_ff + 4'd1;
         if (cmd.round_start) rnd_ff <= '0;
         else if (cmd.round_step) rnd_ff <= rnd_ff + 6'd1;
         if (cmd.fold) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end else if (cmd.emit_shift) begin
            for (int i = 0; i < 7; i++) h_ff[i] <= h_ff[i + 1];
            h_ff[7] <= h_ff[0];
         end
      end
   end

   assign status.word_index = idx_ff;
   assign status.nbytes     = nb_ff;
   assign status.last       = last_ff;
   assign digest_word       = h_ff[0];

endmodule

### hw/rtl/sha256_ctrl.sv
// SHA-256 controller: input handshake, padding sequence, 64-round count
// and digest output. Depends on sha256_pkg.
module sha256_ctrl
   import sha256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   output logic          rsp_digest_last,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PUSH, ST_PAD80, ST_ZERO, ST_LEN_HI, ST_LEN_LO,
      ST_RSTART, ST_ROUND, ST_FOLD, ST_EMIT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       out_ff, out_in;

   // Where to go after a push, compressing first when the block fills.
   function automatic state_type after_push(input logic full, input state_type nxt);
      after_push = full ? ST_RSTART : nxt;
   endfunction

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ret_in   = ret_ff;
      cnt_in   = cnt_ff;
      out_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_input = 1'b1;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_INPUT;
            if (!status.last) ret_in = ST_IDLE;
            else if (status.nbytes == 3'd4) ret_in = ST_PAD80;
            else ret_in = ST_ZERO;
            state_in = after_push(status.word_index == 4'd15, ret_in);
         end
         ST_PAD80: begin
            cmd.push = 1'b1;
            cmd.force_pad = 1'b1;
            ret_in = ST_ZERO;
            state_in = after_push(status.word_index == 4'd15, ST_ZERO);
         end
         ST_ZERO: begin
            if (status.word_index == 4'd14) state_in = ST_LEN_HI;
            else begin
               cmd.push = 1'b1;
               cmd.src  = SRC_ZERO;
               ret_in = ST_ZERO;
               state_in = after_push(status.word_index == 4'd15, ST_ZERO);
            end
         end
         ST_LEN_HI: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_LEN_HI;
            state_in = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_LEN_LO;
            ret_in = ST_EMIT;
            state_in = ST_RSTART;
         end
         ST_RSTART: begin
            cmd.round_start = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            cnt_in = '0;
            state_in = ret_ff;
            out_in = (ret_ff == ST_EMIT);
         end
         ST_EMIT: begin
            out_in = out_ff;
            if (!rsp_stall) begin
               cmd.emit_shift = 1'b1;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  cmd.hash_init = 1'b1;
                  cnt_in = '0;
                  out_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         cnt_ff   <= '0;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
         out_ff   <= out_in;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_last = rsp_valid && (cnt_ff[2:0] == 3'd7);

   a_emit_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> out_ff) else $error("emit without flag");
   a_round_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> (cnt_ff == 6'd0 && $past(cnt_ff) == 6'd63))
      else $error("fold after partial rounds");
   a_one_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_PUSH))
      else $error("accept did not push");

endmodule

### hw/rtl/sha256_hash_engine_unit.sv
// SHA-256 hash engine, top level.
// Channels: req_ takes one 32-bit big-endian message word per transaction
// with its valid byte count and end-of-message mark; rsp_ returns the eight
// digest words H0..H7, rsp_digest_last high on H7. Both use valid/stall.
// A word is latched, then pushed into the block buffer; the word that fills
// a 16-word block also runs a compression (load, 64 rounds at one round per
// cycle, fold). The end-marked word pads (up to 17 pushes, one per cycle,
// paused to compress), runs one or two compressions, then presents the
// digest one word per cycle unless stalled. With a single round unit, a new
// word is taken only after the last is pushed and any compression is done.
// One message is worked at a time; req_stall stays high until the digest
// is fully taken. Reset (synchronous, active high) returns the initial
// hash, zero length and word index. A stalled receiver holds the current
// digest word. Depends on sha256_pkg, sha256_ctrl and sha256_datapath.
module sha256_hash_engine_unit
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_digest_last
);

   dp_cmd_type    cmd;
   dp_status_type status;

   sha256_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_digest_last,
      .rsp_stall, .status, .cmd
   );

   sha256_datapath u_dp (
      .clock, .reset, .cmd,
      .in_word     (req_message_word),
      .in_bytes    (req_valid_bytes),
      .in_last     (req_end_of_message),
      .status,
      .digest_word (rsp_digest_word)
   );

endmodule

### tb/sv/tb_sha256_hash_engine_unit.sv
// Testbench for sha256_hash_engine_unit: drives message words, predicts the
// SHA-256 digest of each message and checks every digest word in order.
// Depends on sha256_pkg and the engine RTL.
`timescale 1ns / 100ps

module tb_sha256_hash_engine_unit;
   import sha256_pkg::*;

   typedef struct {
      logic [31:0] digest_word;
      logic        digest_last;
   } digest_entry_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_message_word;
   logic [2:0]  req_valid_bytes;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_digest_word;
   logic        rsp_digest_last;

   digest_entry_type digest_queue[$];
   int unsigned      error_count;
   bit               idle_enable;

   // predictor state
   logic [31:0] blk_words[16];
   logic [31:0] hash_h[8];
   logic [3:0]  blk_index;
   logic [63:0] msg_bits;

   sha256_hash_engine_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_message_word   (req_message_word),
      .req_valid_bytes    (req_valid_bytes),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_digest_last    (rsp_digest_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] v[8];
      logic [31:0] sched[16];
      logic [31:0] w, t1, t2, x15, x2;
      for (int i = 0; i < 8; i++) v[i] = hash_h[i];
      for (int i = 0; i < 16; i++) sched[i] = blk_words[i];
      for (int i = 0; i < 64; i++) begin
         if (i >= 16) begin
            x15 = sched[(i + 1) % 16];
            x2  = sched[(i + 14) % 16];
            sched[i % 16] = sched[i % 16] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                          + sched[(i + 9) % 16]
                          + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
         end
         w  = sched[i % 16];
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w;
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_h[i] += v[i];
   endtask

   task automatic append_word(logic [31:0] w);
      blk_words[blk_index] = w;
      blk_index++;
      if (blk_index == 0) compress_block();
   endtask

   task automatic hash_restart();
      for (int i = 0; i < 8; i++) hash_h[i] = INIT_H[i];
      blk_index = '0;
      msg_bits  = '0;
   endtask

   task automatic predict_digest(logic [31:0] word, logic [2:0] nb_in, logic eom);
      int unsigned      nb;
      logic [31:0]      keep;
      digest_entry_type e;
      nb = (nb_in > 4 || !eom) ? 4 : nb_in;
      if (!eom) begin
         msg_bits += 32;
         append_word(word);
         return;
      end
      msg_bits += 64'(nb * 8);
      if (nb == 4) begin
         append_word(word);
         append_word(PAD_WORD);
      end else begin
         keep = (nb == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nb));
         append_word((word & keep) | (32'h80 << (24 - 8 * nb)));
      end
      if (blk_index == 15) append_word(32'h0);
      while (blk_index < 14) append_word(32'h0);
      append_word(msg_bits[63:32]);
      append_word(msg_bits[31:0]);
      for (int i = 0; i < 8; i++) begin
         e.digest_word = hash_h[i];
         e.digest_last = (i == 7);
         digest_queue.push_back(e);
      end
      hash_restart();
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Check each digest transaction against the oldest expectation.
   always @(posedge clock) begin
      digest_entry_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_digest_word, 32'h0);
         end else begin
            e = digest_queue.pop_front();
            if (rsp_digest_word !== e.digest_word)
               report_mismatch("digest_word", rsp_digest_word, e.digest_word);
            if (rsp_digest_last !== e.digest_last)
               report_mismatch("digest_last", 32'(rsp_digest_last), 32'(e.digest_last));
         end
      end
   end

   int unsigned stall_cycle;

   // Receiver stalls on its own pattern: quiet and busy stretches.
   always @(posedge clock) begin
      int unsigned phase;
      phase = $urandom_range(0, 99);
      stall_cycle++;
      if (reset || !idle_enable) rsp_stall <= 1'b0;
      else if (stall_cycle % 400 < 100) rsp_stall <= 1'b0;
      else rsp_stall <= (phase < 40);
   end

   int unsigned burst_left;

   task automatic send_word(logic [31:0] word, logic [2:0] nb, logic eom);
      int unsigned gap;
      gap = 0;
      if (idle_enable && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
      end
      if (burst_left > 0) burst_left--;
      // drop valid only when a gap comes before this word
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_message_word   <= word;
      req_valid_bytes    <= nb;
      req_end_of_message <= eom;
      predict_digest(word, nb, eom);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic test_directed();
      // empty message
      send_word(32'h0, 3'd0, 1'b1);
      // one to four bytes, plus saturated byte counts
      for (int n = 1; n <= 7; n++) send_word(32'hffffffff, 3'(n), 1'b1);
      // short count without end mark counts as four bytes
      send_word(32'h0, 3'd1, 1'b0);
      send_word(32'h61626380, 3'd3, 1'b1);
      // 14 words then end mark: pad spills into a second block
      for (int i = 0; i < 14; i++) send_word(32'ha5a5a5a5 ^ i, 3'd4, 1'b0);
      send_word(32'h5a5a5a5a, 3'd4, 1'b1);
   endtask

   task automatic test_full_block_boundary();
      // exactly 16 words, end mark with zero bytes at block start
      for (int i = 0; i < 16; i++) send_word($urandom, 3'd4, 1'b0);
      send_word($urandom, 3'd0, 1'b1);
      // 15 words then end mark with 2 bytes
      for (int i = 0; i < 15; i++) send_word($urandom, 3'd4, 1'b0);
      send_word($urandom, 3'd2, 1'b1);
   endtask

   task automatic test_random_messages();
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < 300) begin
         // mostly short messages, occasionally spanning several blocks
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
         for (int i = 0; i < len; i++) send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
         send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
         sent += len + 1;
      end
   endtask

   initial begin
      int unsigned waited;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_message_word   <= '0;
      req_valid_bytes    <= '0;
      req_end_of_message <= 1'b0;
      error_count = 0;
      idle_enable = 1'b0;
      burst_left  = 0;
      hash_restart();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      idle_enable = 1'b1;
      test_full_block_boundary();
      test_random_messages();
      req_valid <= 1'b0;
      waited = 0;
      while (digest_queue.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (error_count == 0 && digest_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_datapath.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_hash_engine_unit.sv
tb/sv/tb_sha256_hash_engine_unit.sv
